>>> rtl/core/lz4d_pkg.sv
// Shared types, constants and interface structs for the LZ4 block decompressor.
// Used by every module in rtl/core; depends on nothing else.
`default_nettype none

package lz4d_pkg;

    // Sizes of the history window and the byte counters.
    localparam int WIN_BYTES  = 65536;
    localparam int WIN_AW     = $clog2(WIN_BYTES);
    localparam int COUNT_BITS = 24;
    localparam int CFG_W      = 24;
    localparam int CAP_W      = (COUNT_BITS < CFG_W) ? COUNT_BITS : CFG_W;
    localparam int CNT_W      = COUNT_BITS + 1;
    localparam int ALU_W      = COUNT_BITS + 3;

    // Largest number of copy bytes produced by one transaction.
    localparam int BURST      = 64;
    localparam int BCNT_W     = $clog2(BURST + 1);

    // Format constants of the LZ4 sequence layout.
    localparam logic [3:0] NIB_EXT   = 4'hf;
    localparam logic [7:0] BYTE_EXT  = 8'hff;
    localparam logic [3:0] MIN_MATCH = 4'd4;

    // Kind of an input transaction.
    typedef enum logic [1:0] {
        REQ_SRC   = 2'd0,
        REQ_DRAIN = 2'd1,
        REQ_EOI   = 2'd2
    } t_req;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DATA   = 3'd0,
        ST_OK     = 3'd1,
        ST_SIZE   = 3'd2,
        ST_FORMAT = 3'd3,
        ST_BUSY   = 3'd4
    } t_status;

    // Where the parser stands within a sequence.
    typedef enum logic [2:0] {
        PH_TOKEN  = 3'd0,
        PH_LITEXT = 3'd1,
        PH_LIT    = 3'd2,
        PH_OFFLO  = 3'd3,
        PH_OFFHI  = 3'd4,
        PH_MEXT   = 3'd5,
        PH_COPY   = 3'd6
    } t_phase;

    // Sticky error kind.
    typedef enum logic [1:0] {
        ERR_NONE   = 2'd0,
        ERR_SIZE   = 2'd1,
        ERR_FORMAT = 2'd2
    } t_err;

    // Sequencer steps.
    typedef enum logic [2:0] {
        S_IDLE   = 3'd0,
        S_DECODE = 3'd1,
        S_LCHK   = 3'd2,
        S_OFFCHK = 3'd3,
        S_MSTART = 3'd4,
        S_MCHK   = 3'd5,
        S_RD     = 3'd6,
        S_WR     = 3'd7
    } t_seq_state;

    // Operations of the shared add/compare unit.
    typedef enum logic [1:0] {
        ALU_SATADD = 2'd0,
        ALU_CMPADD = 2'd1,
        ALU_SUB    = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op            op;
        logic [ALU_W-1:0]   a;
        logic [ALU_W-1:0]   b;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0]   y;
        logic               flag;
    } t_alu_rsp;

    // Window memory control from the sequencer.
    typedef struct packed {
        logic               rd_en;
        logic [WIN_AW-1:0]  rd_addr;
        logic               wr_en;
        logic [WIN_AW-1:0]  wr_addr;
        logic [7:0]         wr_data;
    } t_win_ctl;

    // One result transaction.
    typedef struct packed {
        logic [7:0]         data;
        t_status            status;
        logic               last;
        logic               pending;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/core/lz4d_alu.sv
// Shared add/compare unit: saturating add, add-and-compare against capacity, subtract.
// Depends on lz4d_pkg.
`default_nettype none

module lz4d_alu (
    input  wire lz4d_pkg::t_alu_req          i_req,
    input  wire [lz4d_pkg::COUNT_BITS-1:0]   i_cap,
    input  wire [lz4d_pkg::CNT_W-1:0]        i_lim,
    output lz4d_pkg::t_alu_rsp               o_rsp
);

    logic                       sub;
    logic [lz4d_pkg::ALU_W-1:0] addend;
    logic [lz4d_pkg::ALU_W-1:0] sum;
    logic [lz4d_pkg::ALU_W-1:0] cmp_ref;
    logic                       gt;

    // One adder serves both add and subtract.
    assign sub    = (i_req.op == lz4d_pkg::ALU_SUB);
    assign addend = sub ? ~i_req.b : i_req.b;
    assign sum    = i_req.a + addend + lz4d_pkg::ALU_W'(sub);

    // One comparator: against the saturation limit or against the capacity.
    assign cmp_ref = (i_req.op == lz4d_pkg::ALU_SATADD) ? lz4d_pkg::ALU_W'(i_lim)
                                                        : lz4d_pkg::ALU_W'(i_cap);
    assign gt      = (sum > cmp_ref);

    always_comb begin
        o_rsp.y    = sum;
        o_rsp.flag = gt;
        if (i_req.op == lz4d_pkg::ALU_SATADD && gt) begin
            o_rsp.y = cmp_ref;
        end
        if (sub) begin
            // The top bit of the difference marks a negative result.
            o_rsp.flag = sum[lz4d_pkg::ALU_W-1];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lz4d_window.sv
// History window: 64 KiB byte memory, one write port and one registered read port.
// Depends on lz4d_pkg.
`default_nettype none

module lz4d_window (
    input  wire                        i_clk,
    input  wire lz4d_pkg::t_win_ctl    i_ctl,
    output logic [7:0]                 o_rd_data
);

    logic [7:0] mem [lz4d_pkg::WIN_BYTES];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            mem[i_ctl.wr_addr] <= i_ctl.wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            o_rd_data <= mem[i_ctl.rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lz4d_seq.sv
// Sequencer and parse state of the decompressor; drives the shared unit and the window.
// Depends on lz4d_pkg; works with lz4d_alu and lz4d_window.
`default_nettype none

module lz4d_seq (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_in_valid,
    output logic                              o_in_ready,
    input  wire [1:0]                         i_in_req,
    input  wire [7:0]                         i_in_byte,
    input  wire [lz4d_pkg::COUNT_BITS-1:0]    i_cap,
    input  wire                               i_out_room,
    output logic                              o_emit,
    output lz4d_pkg::t_result                 o_result,
    output lz4d_pkg::t_alu_req                o_alu_req,
    input  wire lz4d_pkg::t_alu_rsp           i_alu_rsp,
    output lz4d_pkg::t_win_ctl                o_win,
    input  wire [7:0]                         i_win_rd_data
);

    localparam int CNT_W  = lz4d_pkg::CNT_W;
    localparam int ALU_W  = lz4d_pkg::ALU_W;
    localparam int WIN_AW = lz4d_pkg::WIN_AW;
    localparam int BCNT_W = lz4d_pkg::BCNT_W;

    lz4d_pkg::t_seq_state r_state, n_state;
    lz4d_pkg::t_phase     r_phase, n_phase;
    lz4d_pkg::t_err       r_err,   n_err;
    lz4d_pkg::t_req       r_req,   n_req;
    logic [7:0]           r_byte,  n_byte;
    logic [CNT_W-1:0]     r_lit,   n_lit;
    logic [CNT_W-1:0]     r_copy,  n_copy;
    logic [15:0]          r_dist,  n_dist;
    logic [3:0]           r_mn,    n_mn;
    logic [CNT_W-1:0]     r_bw,    n_bw;
    logic [BCNT_W-1:0]    r_bcnt,  n_bcnt;
    logic                 r_cpend, n_cpend;

    logic                 accept;
    logic                 adv;
    logic                 busy;
    logic                 copy_last;
    logic                 off_bad;
    lz4d_pkg::t_win_ctl   win_raw;
    lz4d_pkg::t_status    eoi_status;

    assign accept    = i_in_valid && o_in_ready;
    assign busy      = (r_phase == lz4d_pkg::PH_COPY);
    assign copy_last = (r_copy == CNT_W'(1)) || (r_bcnt == BCNT_W'(lz4d_pkg::BURST - 1));
    assign off_bad   = (r_dist == 16'd0) || i_alu_rsp.flag;

    // A step that produces a result waits until the output register has room.
    assign adv = !(o_emit && !i_out_room);

    // Outcome reported at end of input.
    always_comb begin
        if (r_err == lz4d_pkg::ERR_SIZE) begin
            eoi_status = lz4d_pkg::ST_SIZE;
        end else if (r_err != lz4d_pkg::ERR_NONE) begin
            eoi_status = lz4d_pkg::ST_FORMAT;
        end else if (r_phase == lz4d_pkg::PH_TOKEN || r_phase == lz4d_pkg::PH_OFFLO) begin
            eoi_status = (r_bw == CNT_W'(i_cap)) ? lz4d_pkg::ST_OK : lz4d_pkg::ST_SIZE;
        end else if (r_phase == lz4d_pkg::PH_LIT) begin
            eoi_status = lz4d_pkg::ST_SIZE;
        end else begin
            eoi_status = lz4d_pkg::ST_FORMAT;
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lz4d_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = lz4d_pkg::S_DECODE;
                end
            end
            lz4d_pkg::S_DECODE: begin
                n_state = lz4d_pkg::S_IDLE;
                case (r_req)
                    lz4d_pkg::REQ_SRC: begin
                        if (!busy && r_err == lz4d_pkg::ERR_NONE) begin
                            case (r_phase)
                                lz4d_pkg::PH_TOKEN: begin
                                    if (r_byte[7:4] != lz4d_pkg::NIB_EXT) begin
                                        n_state = lz4d_pkg::S_LCHK;
                                    end
                                end
                                lz4d_pkg::PH_LITEXT: begin
                                    if (r_byte != lz4d_pkg::BYTE_EXT) begin
                                        n_state = lz4d_pkg::S_LCHK;
                                    end
                                end
                                lz4d_pkg::PH_OFFHI: begin
                                    n_state = lz4d_pkg::S_OFFCHK;
                                end
                                lz4d_pkg::PH_MEXT: begin
                                    if (r_byte != lz4d_pkg::BYTE_EXT) begin
                                        n_state = lz4d_pkg::S_MSTART;
                                    end
                                end
                                default: begin
                                    n_state = lz4d_pkg::S_IDLE;
                                end
                            endcase
                        end
                    end
                    lz4d_pkg::REQ_DRAIN: begin
                        if (busy && r_err == lz4d_pkg::ERR_NONE) begin
                            n_state = lz4d_pkg::S_RD;
                        end
                    end
                    default: begin
                        n_state = lz4d_pkg::S_IDLE;
                    end
                endcase
            end
            lz4d_pkg::S_LCHK: begin
                n_state = lz4d_pkg::S_IDLE;
            end
            lz4d_pkg::S_OFFCHK: begin
                if (off_bad || r_mn == lz4d_pkg::NIB_EXT) begin
                    n_state = lz4d_pkg::S_IDLE;
                end else begin
                    n_state = lz4d_pkg::S_MSTART;
                end
            end
            lz4d_pkg::S_MSTART: begin
                n_state = lz4d_pkg::S_MCHK;
            end
            lz4d_pkg::S_MCHK: begin
                n_state = i_alu_rsp.flag ? lz4d_pkg::S_IDLE : lz4d_pkg::S_RD;
            end
            lz4d_pkg::S_RD: begin
                n_state = lz4d_pkg::S_WR;
            end
            lz4d_pkg::S_WR: begin
                n_state = copy_last ? lz4d_pkg::S_IDLE : lz4d_pkg::S_RD;
            end
            default: begin
                n_state = lz4d_pkg::S_IDLE;
            end
        endcase
    end

    // Datapath updates, shared-unit requests, window access and results.
    always_comb begin
        n_phase   = r_phase;
        n_err     = r_err;
        n_req     = r_req;
        n_byte    = r_byte;
        n_lit     = r_lit;
        n_copy    = r_copy;
        n_dist    = r_dist;
        n_mn      = r_mn;
        n_bw      = r_bw;
        n_bcnt    = r_bcnt;
        n_cpend   = r_cpend;

        o_alu_req.op = lz4d_pkg::ALU_SUB;
        o_alu_req.a  = ALU_W'(r_bw);
        o_alu_req.b  = ALU_W'(r_dist);

        win_raw.rd_en   = 1'b0;
        win_raw.rd_addr = i_alu_rsp.y[WIN_AW-1:0];
        win_raw.wr_en   = 1'b0;
        win_raw.wr_addr = r_bw[WIN_AW-1:0];
        win_raw.wr_data = r_byte;

        o_emit           = 1'b0;
        o_result.data    = 8'd0;
        o_result.status  = lz4d_pkg::ST_DATA;
        o_result.last    = 1'b1;
        o_result.pending = 1'b0;

        unique case (r_state)
            lz4d_pkg::S_IDLE: begin
                if (accept) begin
                    n_req  = lz4d_pkg::t_req'(i_in_req);
                    n_byte = i_in_byte;
                end
            end

            lz4d_pkg::S_DECODE: begin
                // Extension bytes feed the saturating adder.
                o_alu_req.op = lz4d_pkg::ALU_SATADD;
                o_alu_req.b  = ALU_W'(r_byte);
                o_alu_req.a  = (r_phase == lz4d_pkg::PH_MEXT) ? ALU_W'(r_copy)
                                                              : ALU_W'(r_lit);
                case (r_req)
                    lz4d_pkg::REQ_SRC: begin
                        if (busy) begin
                            o_emit           = 1'b1;
                            o_result.status  = lz4d_pkg::ST_BUSY;
                            o_result.pending = 1'b1;
                        end else if (r_err == lz4d_pkg::ERR_NONE) begin
                            case (r_phase)
                                lz4d_pkg::PH_TOKEN: begin
                                    n_lit = CNT_W'(r_byte[7:4]);
                                    n_mn  = r_byte[3:0];
                                    if (r_byte[7:4] == lz4d_pkg::NIB_EXT) begin
                                        n_phase = lz4d_pkg::PH_LITEXT;
                                    end
                                end
                                lz4d_pkg::PH_LITEXT: begin
                                    n_lit = i_alu_rsp.y[CNT_W-1:0];
                                end
                                lz4d_pkg::PH_LIT: begin
                                    // Literal byte goes to the window and out.
                                    win_raw.wr_en = 1'b1;
                                    o_emit        = 1'b1;
                                    o_result.data = r_byte;
                                    n_bw          = r_bw + CNT_W'(1);
                                    n_lit         = r_lit - CNT_W'(1);
                                    if (r_lit == CNT_W'(1)) begin
                                        n_phase = lz4d_pkg::PH_OFFLO;
                                    end
                                end
                                lz4d_pkg::PH_OFFLO: begin
                                    n_dist  = {8'd0, r_byte};
                                    n_phase = lz4d_pkg::PH_OFFHI;
                                end
                                lz4d_pkg::PH_OFFHI: begin
                                    n_dist = {r_byte, r_dist[7:0]};
                                end
                                lz4d_pkg::PH_MEXT: begin
                                    n_copy = i_alu_rsp.y[CNT_W-1:0];
                                end
                                default: begin
                                    n_phase = r_phase;
                                end
                            endcase
                        end
                    end
                    lz4d_pkg::REQ_DRAIN: begin
                        n_bcnt  = '0;
                        n_cpend = (r_copy > CNT_W'(lz4d_pkg::BURST));
                    end
                    lz4d_pkg::REQ_EOI: begin
                        o_emit = 1'b1;
                        if (busy) begin
                            o_result.status  = lz4d_pkg::ST_BUSY;
                            o_result.pending = 1'b1;
                        end else begin
                            o_result.status = eoi_status;
                            n_phase = lz4d_pkg::PH_TOKEN;
                            n_lit   = '0;
                            n_copy  = '0;
                            n_dist  = '0;
                            n_mn    = '0;
                            n_bw    = '0;
                            n_err   = lz4d_pkg::ERR_NONE;
                        end
                    end
                    default: begin
                        n_req = r_req;
                    end
                endcase
            end

            lz4d_pkg::S_LCHK: begin
                // Literal run must fit in the room left.
                o_alu_req.op = lz4d_pkg::ALU_CMPADD;
                o_alu_req.a  = ALU_W'(r_bw);
                o_alu_req.b  = ALU_W'(r_lit);
                if (i_alu_rsp.flag) begin
                    o_emit          = 1'b1;
                    o_result.status = lz4d_pkg::ST_SIZE;
                    n_err           = lz4d_pkg::ERR_SIZE;
                    n_phase         = lz4d_pkg::PH_TOKEN;
                    n_lit           = '0;
                    n_copy          = '0;
                end else begin
                    n_phase = (r_lit != '0) ? lz4d_pkg::PH_LIT : lz4d_pkg::PH_OFFLO;
                end
            end

            lz4d_pkg::S_OFFCHK: begin
                // Offset must be nonzero and within the bytes produced so far.
                if (off_bad) begin
                    o_emit          = 1'b1;
                    o_result.status = lz4d_pkg::ST_FORMAT;
                    n_err           = lz4d_pkg::ERR_FORMAT;
                    n_phase         = lz4d_pkg::PH_TOKEN;
                    n_lit           = '0;
                    n_copy          = '0;
                end else if (r_mn == lz4d_pkg::NIB_EXT) begin
                    n_copy  = CNT_W'(lz4d_pkg::NIB_EXT);
                    n_phase = lz4d_pkg::PH_MEXT;
                end else begin
                    n_copy = CNT_W'(r_mn);
                end
            end

            lz4d_pkg::S_MSTART: begin
                // Add the minimum match length.
                o_alu_req.op = lz4d_pkg::ALU_SATADD;
                o_alu_req.a  = ALU_W'(r_copy);
                o_alu_req.b  = ALU_W'(lz4d_pkg::MIN_MATCH);
                n_copy       = i_alu_rsp.y[CNT_W-1:0];
            end

            lz4d_pkg::S_MCHK: begin
                // Match must fit in the room left.
                o_alu_req.op = lz4d_pkg::ALU_CMPADD;
                o_alu_req.a  = ALU_W'(r_bw);
                o_alu_req.b  = ALU_W'(r_copy);
                if (i_alu_rsp.flag) begin
                    o_emit          = 1'b1;
                    o_result.status = lz4d_pkg::ST_SIZE;
                    n_err           = lz4d_pkg::ERR_SIZE;
                    n_phase         = lz4d_pkg::PH_TOKEN;
                    n_lit           = '0;
                    n_copy          = '0;
                end else begin
                    n_phase = lz4d_pkg::PH_COPY;
                    n_bcnt  = '0;
                    n_cpend = (r_copy > CNT_W'(lz4d_pkg::BURST));
                end
            end

            lz4d_pkg::S_RD: begin
                // Source address is the write pointer minus the offset.
                win_raw.rd_en = 1'b1;
            end

            lz4d_pkg::S_WR: begin
                // Copied byte goes back into the window and out.
                win_raw.wr_en    = 1'b1;
                win_raw.wr_data  = i_win_rd_data;
                o_emit           = 1'b1;
                o_result.data    = i_win_rd_data;
                o_result.last    = copy_last;
                o_result.pending = r_cpend;
                n_bw             = r_bw + CNT_W'(1);
                n_copy           = r_copy - CNT_W'(1);
                n_bcnt           = r_bcnt + BCNT_W'(1);
                if (copy_last) begin
                    n_phase = (r_copy != CNT_W'(1)) ? lz4d_pkg::PH_COPY
                                                    : lz4d_pkg::PH_TOKEN;
                end
            end

            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // Window access only on steps that go ahead.
    always_comb begin
        o_win       = win_raw;
        o_win.rd_en = win_raw.rd_en && adv;
        o_win.wr_en = win_raw.wr_en && adv;
    end

    assign o_in_ready = (r_state == lz4d_pkg::S_IDLE);

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lz4d_pkg::S_IDLE;
            r_phase <= lz4d_pkg::PH_TOKEN;
            r_err   <= lz4d_pkg::ERR_NONE;
            r_lit   <= '0;
            r_copy  <= '0;
            r_dist  <= '0;
            r_mn    <= '0;
            r_bw    <= '0;
            r_bcnt  <= '0;
            r_cpend <= 1'b0;
        end else if (adv) begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_err   <= n_err;
            r_lit   <= n_lit;
            r_copy  <= n_copy;
            r_dist  <= n_dist;
            r_mn    <= n_mn;
            r_bw    <= n_bw;
            r_bcnt  <= n_bcnt;
            r_cpend <= n_cpend;
        end
    end

    // Captured transaction payload.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_req  <= n_req;
            r_byte <= n_byte;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lz4_block_decompressor_top.sv
// Top level of the LZ4 block decompressor: ports, capacity register, output register.
// Depends on lz4d_pkg, lz4d_alu, lz4d_window and lz4d_seq.
//
// Channel    Direction  Handshake                      Contents
// s_axis     in         s_axis_tvalid / s_axis_tready  tdata: in_byte; tuser: req_type
// m_axis     out        m_axis_tvalid / m_axis_tready  tdata: out_byte; tuser: status,
//                                                      pending; tlast: last
// cfg        in         i_cfg_wr_en                    i_cfg_wr_data: out_capacity
//
// Token, length-extension and offset bytes pass through the shared add/compare unit.
// A literal byte goes to the window and out as it is decoded; a match copies each byte with a
// window read, then a write-back, up to 64 bytes per transaction. Reset is synchronous and
// active low; the window is not cleared and needs no clearing pass.
// A full output register holds the sequencer on steps that produce a result; the input is taken only when it is idle.
`default_nettype none

module lz4_block_decompressor_top (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,     // [7:0] in_byte
    input  wire [1:0]   s_axis_tuser,     // [1:0] req_type
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,     // [7:0] out_byte
    output logic [3:0]  m_axis_tuser,     // [2:0] status, [3] pending
    output logic        m_axis_tlast,
    input  wire         i_cfg_wr_en,
    input  wire [lz4d_pkg::CFG_W-1:0] i_cfg_wr_data
);

    localparam int COUNT_BITS = lz4d_pkg::COUNT_BITS;
    localparam int CNT_W      = lz4d_pkg::CNT_W;

    logic [COUNT_BITS-1:0] r_cap;
    logic [CNT_W-1:0]      r_lim;
    logic                  r_m_valid;
    lz4d_pkg::t_result     r_m_res;

    logic                  out_room;
    logic                  emit;
    lz4d_pkg::t_result     result;
    lz4d_pkg::t_alu_req    alu_req;
    lz4d_pkg::t_alu_rsp    alu_rsp;
    lz4d_pkg::t_win_ctl    win_ctl;
    logic [7:0]            win_rd_data;

    // Capacity register and its saturation limit.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
            r_lim <= CNT_W'(1);
        end else if (i_cfg_wr_en) begin
            r_cap <= COUNT_BITS'(i_cfg_wr_data[lz4d_pkg::CAP_W-1:0]);
            r_lim <= CNT_W'(i_cfg_wr_data[lz4d_pkg::CAP_W-1:0]) + CNT_W'(1);
        end
    end

    lz4d_seq u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (s_axis_tvalid),
        .o_in_ready    (s_axis_tready),
        .i_in_req      (s_axis_tuser),
        .i_in_byte     (s_axis_tdata),
        .i_cap         (r_cap),
        .i_out_room    (out_room),
        .o_emit        (emit),
        .o_result      (result),
        .o_alu_req     (alu_req),
        .i_alu_rsp     (alu_rsp),
        .o_win         (win_ctl),
        .i_win_rd_data (win_rd_data)
    );

    lz4d_alu u_alu (
        .i_req (alu_req),
        .i_cap (r_cap),
        .i_lim (r_lim),
        .o_rsp (alu_rsp)
    );

    lz4d_window u_window (
        .i_clk     (i_clk),
        .i_ctl     (win_ctl),
        .o_rd_data (win_rd_data)
    );

    // Output register: loads when empty or being drained in the same cycle.
    assign out_room = !r_m_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (emit && out_room) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit && out_room) begin
            r_m_res <= result;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_res.data;
    assign m_axis_tuser  = {r_m_res.pending, r_m_res.status};
    assign m_axis_tlast  = r_m_res.last;

endmodule

`default_nettype wire
